// ===== rtl/core/bpbo_pkg.sv =====
// Package for the bit-packed base-offset decoder.
// Holds the command type, field widths and the low-bit mask helper.
// No dependencies.
package bpbo_pkg;

  typedef enum logic {
    CMD_HEADER  = 1'b0,
    CMD_PAYLOAD = 1'b1
  } cmd_t;

  localparam int VALUE_W  = 32;
  localparam int BYTE_W   = 8;
  localparam int WIDTH_W  = 6;
  localparam int POS_W    = 4;
  localparam int WIDE_W   = VALUE_W + BYTE_W;
  localparam int CNT_IN_W = 16;

  localparam logic [BYTE_W-1:0] BYTE_MASK = 8'hff;

  function automatic logic [BYTE_W-1:0] low_mask(input logic [POS_W-1:0] n);
    logic [BYTE_W:0] one_hot;
    one_hot = (BYTE_W+1)'(1) << n;
    return BYTE_W'(one_hot - (BYTE_W+1)'(1));
  endfunction

endpackage

// ===== rtl/core/bitpacked_base_offset_decoder.sv =====
// Top level of the bit-packed base-offset decoder.
// Depends on bpbo_pkg for command codes, widths and the mask helper.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one word per item: a batch
//   header (command = header) or one payload byte (command = payload).
//   Output channel (out_valid / out_stall) carries one decoded value per word.
//   A header gives exactly one result carrying first_value. Each payload byte
//   gives zero to eight results: every completed field plus the batch base.
//   The work register holds an accepted word, and its first result is then
//   registered into the result register.
//   Throughput: one input word per cycle while the receiver does not stall and
//   each byte completes at most one field; a byte that completes several fields
//   holds the input until its last field is done, set by the single-field
//   extractor between the work register and result register. A payload byte
//   that completes no field, or arrives with no batch open, gives no result.
//   Reset clears the bit accumulator, batch count, width and base, and empties
//   both the work and result registers.
//   When the receiver stalls, the result register holds its word and the work
//   register holds its byte; in_stall rises once the work register is full
//   and cannot finish in this cycle.
module bitpacked_base_offset_decoder #(
  parameter int MAX_FIELD_WIDTH = 32,
  parameter int COUNT_BITS      = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  command,
  input  logic [bpbo_pkg::CNT_IN_W-1:0]         value_count,
  input  logic [bpbo_pkg::WIDTH_W-1:0]          field_width,
  input  logic signed [bpbo_pkg::VALUE_W-1:0]   base_offset,
  input  logic signed [bpbo_pkg::VALUE_W-1:0]   first_value,
  input  logic [bpbo_pkg::BYTE_W-1:0]           payload_byte,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [bpbo_pkg::VALUE_W-1:0]   value,
  output logic                                  last_of_run,
  output logic                                  batch_done,
  output logic                                  error
);

  localparam int AW = MAX_FIELD_WIDTH;

  // work register
  logic                               w_vld;
  bpbo_pkg::cmd_t                     w_cmd;
  logic [bpbo_pkg::CNT_IN_W-1:0]      w_count;
  logic [bpbo_pkg::WIDTH_W-1:0]       w_width;
  logic [bpbo_pkg::VALUE_W-1:0]       w_base;
  logic [bpbo_pkg::VALUE_W-1:0]       w_first;
  logic [bpbo_pkg::BYTE_W-1:0]        w_byte;
  logic [bpbo_pkg::POS_W-1:0]         pos;

  // batch state
  logic [AW-1:0]                      acc;
  logic [bpbo_pkg::WIDTH_W-1:0]       held;
  logic [COUNT_BITS-1:0]              values_left;
  logic [bpbo_pkg::WIDTH_W-1:0]       active_width;
  logic [bpbo_pkg::VALUE_W-1:0]       active_base;

  // step logic
  logic                               in_accept;
  logic                               out_free;
  logic                               step_go;
  logic                               finish;
  logic                               emit;
  logic                               bad;
  logic [COUNT_BITS-1:0]              cnt_ext;
  logic [bpbo_pkg::POS_W-1:0]         avail;
  logic [bpbo_pkg::WIDTH_W-1:0]       need;
  logic [bpbo_pkg::POS_W-1:0]         rest;
  logic [bpbo_pkg::BYTE_W-1:0]        rem;
  logic [bpbo_pkg::BYTE_W-1:0]        taken;
  logic [bpbo_pkg::BYTE_W-1:0]        leftover;
  logic [bpbo_pkg::WIDE_W-1:0]        field_wide;
  logic [bpbo_pkg::WIDE_W-1:0]        absorb_wide;
  logic [COUNT_BITS-1:0]              vl_dec;
  logic                               pay_emit;
  logic                               pay_fits;

  logic [AW-1:0]                      acc_next;
  logic [bpbo_pkg::WIDTH_W-1:0]       held_next;
  logic [COUNT_BITS-1:0]              values_left_next;
  logic [bpbo_pkg::POS_W-1:0]         pos_next;
  logic [bpbo_pkg::VALUE_W-1:0]       value_next;
  logic                               last_next;
  logic                               done_next;
  logic                               error_next;

  assign out_free  = !out_valid || !out_stall;
  assign step_go   = w_vld && out_free;
  assign in_stall  = w_vld && !(step_go && finish);
  assign in_accept = in_valid && !in_stall;

  assign cnt_ext  = COUNT_BITS'(w_count);
  assign bad      = (w_width == '0) ||
                    (w_width > bpbo_pkg::WIDTH_W'(MAX_FIELD_WIDTH));
  assign avail    = bpbo_pkg::POS_W'(bpbo_pkg::BYTE_W) - pos;
  assign need     = active_width - held;
  assign rem      = w_byte & (bpbo_pkg::BYTE_MASK >> pos);
  assign pay_fits = need <= bpbo_pkg::WIDTH_W'(avail);
  assign pay_emit = (values_left != '0) && pay_fits;
  assign rest     = avail - need[bpbo_pkg::POS_W-1:0];
  assign taken    = rem >> rest;
  assign leftover = rem & bpbo_pkg::low_mask(rest);
  assign vl_dec   = values_left - COUNT_BITS'(1);

  assign field_wide  = (bpbo_pkg::WIDE_W'(acc) << need) | bpbo_pkg::WIDE_W'(taken);
  assign absorb_wide = (bpbo_pkg::WIDE_W'(acc) << avail) | bpbo_pkg::WIDE_W'(rem);

  always_comb begin
    acc_next         = acc;
    held_next        = held;
    values_left_next = values_left;
    pos_next         = pos;
    finish           = 1'b1;
    emit             = 1'b0;
    value_next       = '0;
    last_next        = 1'b0;
    done_next        = 1'b0;
    error_next       = 1'b0;
    case (w_cmd)
      bpbo_pkg::CMD_HEADER: begin
        acc_next         = '0;
        held_next        = '0;
        values_left_next = bad ? '0 : cnt_ext;
        emit             = 1'b1;
        value_next       = w_first;
        last_next        = 1'b1;
        done_next        = bad || (cnt_ext == '0);
        error_next       = bad;
      end
      bpbo_pkg::CMD_PAYLOAD: begin
        if (values_left == '0) begin
          finish = 1'b1;
        end else if (pay_emit) begin
          emit             = 1'b1;
          values_left_next = vl_dec;
          value_next       = bpbo_pkg::VALUE_W'(field_wide[AW-1:0]) + active_base;
          done_next        = (vl_dec == '0);
          finish           = (vl_dec == '0) ||
                             (bpbo_pkg::WIDTH_W'(rest) < active_width);
          last_next        = finish;
          pos_next         = pos + need[bpbo_pkg::POS_W-1:0];
          if (vl_dec == '0) begin
            acc_next  = '0;
            held_next = '0;
          end else if (finish) begin
            acc_next  = AW'(leftover);
            held_next = bpbo_pkg::WIDTH_W'(rest);
          end else begin
            acc_next  = '0;
            held_next = '0;
          end
        end else begin
          acc_next  = absorb_wide[AW-1:0];
          held_next = held + bpbo_pkg::WIDTH_W'(avail);
        end
      end
      default: begin
        finish = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_vld <= 1'b0;
    end else if (in_accept) begin
      w_vld <= 1'b1;
    end else if (step_go && finish) begin
      w_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      w_cmd   <= bpbo_pkg::cmd_t'(command);
      w_count <= value_count;
      w_width <= field_width;
      w_base  <= base_offset;
      w_first <= first_value;
      w_byte  <= payload_byte;
      pos     <= '0;
    end else if (step_go) begin
      pos     <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc          <= '0;
      held         <= '0;
      values_left  <= '0;
      active_width <= '0;
      active_base  <= '0;
    end else if (step_go) begin
      acc         <= acc_next;
      held        <= held_next;
      values_left <= values_left_next;
      if (w_cmd == bpbo_pkg::CMD_HEADER) begin
        active_width <= w_width;
        active_base  <= w_base;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step_go && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go && emit) begin
      value       <= value_next;
      last_of_run <= last_next;
      batch_done  <= done_next;
      error       <= error_next;
    end
  end

`ifndef SYNTH
  a_error_ends_batch: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> batch_done && last_of_run)
    else $error("error result without batch_done");

  a_header_result: assert property (@(posedge clk) disable iff (rst)
    step_go && w_cmd == bpbo_pkg::CMD_HEADER |=> out_valid && last_of_run)
    else $error("header gave no result");

  a_partial_short: assert property (@(posedge clk) disable iff (rst)
    values_left != '0 |-> held < active_width)
    else $error("held bits reached field width");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    w_vld |-> pos <= bpbo_pkg::POS_W'(bpbo_pkg::BYTE_W))
    else $error("bit position past byte");
`endif

endmodule
